// ===== rtl/crc8wfb_pkg.sv =====
// crc8wfb_pkg: constants, types and the crc-8 update for the write frame builder
// no dependencies; used by crc8wfb_frame_mux and crc8_write_frame_builder

package crc8wfb_pkg;

    // frame constants
    localparam logic [7:0] FRAME_START      = 8'h53;
    localparam logic [7:0] FRAME_END        = 8'h45;
    localparam logic [7:0] FRAME_MODE_WRITE = 8'h02;
    localparam logic [7:0] FRAME_SUBINDEX   = 8'h00;
    localparam logic [7:0] FRAME_LEN_SHORT  = 8'h09;  // base length 7 plus two data bytes
    localparam logic [7:0] FRAME_LEN_WIDE   = 8'h0B;  // base length 7 plus four data bytes
    localparam logic [7:0] CRC_POLY         = 8'hD5;
    localparam logic [7:0] CRC_INIT         = 8'hFF;
    localparam logic [7:0] NODE_ADDR_RESET  = 8'h01;

    // byte positions within a frame
    localparam logic [3:0] POS_START     = 4'd0;
    localparam logic [3:0] POS_LEN       = 4'd1;
    localparam logic [3:0] POS_NODE      = 4'd2;
    localparam logic [3:0] POS_MODE      = 4'd3;
    localparam logic [3:0] POS_IDX_LO    = 4'd4;
    localparam logic [3:0] POS_IDX_HI    = 4'd5;
    localparam logic [3:0] POS_SUB       = 4'd6;
    localparam logic [3:0] POS_DATA0     = 4'd7;
    localparam logic [3:0] POS_DATA1     = 4'd8;
    localparam logic [3:0] POS_DATA2     = 4'd9;
    localparam logic [3:0] POS_DATA3     = 4'd10;
    localparam logic [3:0] POS_CRC_SHORT = 4'd9;
    localparam logic [3:0] POS_CRC_WIDE  = 4'd11;
    localparam logic [3:0] POS_END_WIDE  = 4'd12;

    // held write request
    typedef struct packed {
        logic [15:0] object_index;
        logic [31:0] data_value;
        logic        wide_data;
    } write_req_t;

    // what the frame mux hands back for the current position
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [7:0] crc_next;
    } frame_out_t;

    // reflected crc-8, one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (v[0])
            begin
                v = (v >> 1) ^ CRC_POLY;
            end
            else
            begin
                v = v >> 1;
            end
        end
        return v;
    endfunction

endpackage

// ===== rtl/crc8_write_frame_builder.sv =====
// a taken item passes request register, frame engine, then the output register
// throughput: one byte per cycle while m_tready is high, set by the single output
//   byte register; frames of 11 (short) or 13 (wide) bytes go back to back, no gap
// a one-deep request register accepts the next item while a frame is being sent
// reset: rst_n asynchronous active low; clears handshake state, node_address to 1
// depends on crc8wfb_pkg and crc8wfb_frame_mux

module crc8_write_frame_builder
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration: node_address
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,

    // request items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // [15:0] object_index, [47:16] data_value
    input  logic        s_tuser,    // [0] wide_data

    // frame byte items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] frame_byte
    output logic        m_tlast     // last_byte
);

    // node address register
    logic [7:0] node_addr_reg;

    // request holding register (skid between input and frame engine)
    logic                     req_valid_reg;
    logic                     req_valid_next;
    crc8wfb_pkg::write_req_t  req_reg;
    crc8wfb_pkg::write_req_t  req_next;

    // frame engine state
    logic                     frm_active_reg;
    logic                     frm_active_next;
    logic [3:0]               pos_reg;
    logic [3:0]               pos_next;
    logic [7:0]               crc_reg;
    logic [7:0]               crc_next;
    crc8wfb_pkg::write_req_t  frm_req_reg;
    crc8wfb_pkg::write_req_t  frm_req_next;

    // output byte register
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [7:0]               out_data_reg;
    logic [7:0]               out_data_next;
    logic                     out_last_reg;
    logic                     out_last_next;

    crc8wfb_pkg::frame_out_t  sel;
    logic                     emit;
    logic                     frame_done;
    logic                     load;

    // byte selection and crc step for the current position
    crc8wfb_frame_mux u_frame_mux
    (
        .pos          (pos_reg),
        .req          (frm_req_reg),
        .node_address (node_addr_reg),
        .crc          (crc_reg),
        .result       (sel)
    );

    // a byte moves into the output register when it is empty or being drained
    assign emit       = frm_active_reg && (!out_valid_reg || m_tready);
    assign frame_done = emit && sel.last;
    // next request starts as soon as the end byte leaves the engine
    assign load       = req_valid_reg && (!frm_active_reg || frame_done);
    assign s_tready   = !req_valid_reg || load;

    // request register
    always_comb
    begin
        req_valid_next = req_valid_reg;
        req_next       = req_reg;
        if (s_tready)
        begin
            req_valid_next = s_tvalid;
            if (s_tvalid)
            begin
                req_next.object_index = s_tdata[15:0];
                req_next.data_value   = s_tdata[47:16];
                req_next.wide_data    = s_tuser;
            end
        end
    end

    // frame engine
    always_comb
    begin
        frm_active_next = frm_active_reg;
        pos_next        = pos_reg;
        crc_next        = crc_reg;
        frm_req_next    = frm_req_reg;
        if (load)
        begin
            frm_active_next = 1'b1;
            pos_next        = crc8wfb_pkg::POS_START;
            crc_next        = crc8wfb_pkg::CRC_INIT;
            frm_req_next    = req_reg;
        end
        else if (emit)
        begin
            pos_next = pos_reg + 4'd1;
            crc_next = sel.crc_next;
            if (sel.last)
            begin
                frm_active_next = 1'b0;
                pos_next        = crc8wfb_pkg::POS_START;
                crc_next        = crc8wfb_pkg::CRC_INIT;
            end
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = sel.data;
            out_last_next  = sel.last;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_addr_reg  <= crc8wfb_pkg::NODE_ADDR_RESET;
            req_valid_reg  <= 1'b0;
            frm_active_reg <= 1'b0;
            pos_reg        <= crc8wfb_pkg::POS_START;
            crc_reg        <= crc8wfb_pkg::CRC_INIT;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                node_addr_reg <= cfg_wdata;
            end
            req_valid_reg  <= req_valid_next;
            frm_active_reg <= frm_active_next;
            pos_reg        <= pos_next;
            crc_reg        <= crc_next;
            out_valid_reg  <= out_valid_next;
            out_last_reg   <= out_last_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        frm_req_reg  <= frm_req_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // the end-of-frame flag only ever marks the end byte
    a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata == crc8wfb_pkg::FRAME_END))
        else $error("tlast on a byte other than the end byte");

    // position never runs past the end of a wide frame
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= crc8wfb_pkg::POS_END_WIDE)
        else $error("frame position out of range");

    // every frame starts with a fresh crc
    a_crc_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        (frm_active_reg && (pos_reg == crc8wfb_pkg::POS_START))
            |-> (crc_reg == crc8wfb_pkg::CRC_INIT))
        else $error("crc not reset at frame start");

    // a byte sent from the start position is always the frame start byte
    a_start_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (pos_reg == crc8wfb_pkg::POS_START)) |-> (sel.data == crc8wfb_pkg::FRAME_START))
        else $error("frame start byte wrong");
`endif

endmodule

// ===== rtl/crc8wfb_frame_mux.sv =====
// crc8wfb_frame_mux: selects the frame byte for a position and advances the crc
// depends on crc8wfb_pkg

module crc8wfb_frame_mux
(
    input  logic [3:0]               pos,
    input  crc8wfb_pkg::write_req_t  req,
    input  logic [7:0]               node_address,
    input  logic [7:0]               crc,
    output crc8wfb_pkg::frame_out_t  result
);

    logic [3:0] crc_pos;
    logic [3:0] end_pos;
    logic [7:0] sel_byte;
    logic       covered;

    assign crc_pos = req.wide_data ? crc8wfb_pkg::POS_CRC_WIDE : crc8wfb_pkg::POS_CRC_SHORT;
    assign end_pos = crc_pos + 4'd1;

    always_comb
    begin
        sel_byte = 8'h00;
        if (pos == crc_pos)
        begin
            sel_byte = crc;
        end
        else if (pos == end_pos)
        begin
            sel_byte = crc8wfb_pkg::FRAME_END;
        end
        else
        begin
            case (pos)
                crc8wfb_pkg::POS_START:  sel_byte = crc8wfb_pkg::FRAME_START;
                crc8wfb_pkg::POS_LEN:    sel_byte = req.wide_data ? crc8wfb_pkg::FRAME_LEN_WIDE
                                                                  : crc8wfb_pkg::FRAME_LEN_SHORT;
                crc8wfb_pkg::POS_NODE:   sel_byte = node_address;
                crc8wfb_pkg::POS_MODE:   sel_byte = crc8wfb_pkg::FRAME_MODE_WRITE;
                crc8wfb_pkg::POS_IDX_LO: sel_byte = req.object_index[7:0];
                crc8wfb_pkg::POS_IDX_HI: sel_byte = req.object_index[15:8];
                crc8wfb_pkg::POS_SUB:    sel_byte = crc8wfb_pkg::FRAME_SUBINDEX;
                crc8wfb_pkg::POS_DATA0:  sel_byte = req.data_value[7:0];
                crc8wfb_pkg::POS_DATA1:  sel_byte = req.data_value[15:8];
                crc8wfb_pkg::POS_DATA2:  sel_byte = req.data_value[23:16];
                crc8wfb_pkg::POS_DATA3:  sel_byte = req.data_value[31:24];
                default:                 sel_byte = 8'h00;
            endcase
        end
    end

    // crc covers length byte through last data byte
    assign covered = (pos != crc8wfb_pkg::POS_START) && (pos < crc_pos);

    assign result.data     = sel_byte;
    assign result.last     = (pos == end_pos);
    assign result.crc_next = covered ? crc8wfb_pkg::crc8_update(crc, sel_byte) : crc;

endmodule

// ===== sim/crc8_write_frame_builder_tb.sv =====
// crc8_write_frame_builder_tb: self-checking bench for the crc-8 write frame builder
// predicts every frame byte from the request items and compares each output item in order
// depends on crc8wfb_pkg and crc8_write_frame_builder
`timescale 1ns / 100ps

module crc8_write_frame_builder_tb;

    // run limit, far above the slowest legal run (about 110 frames of 13 bytes,
    // each byte behind a random receiver stall, plus gaps, hold-off and drains)
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int SETTLE_CYCLES = 6;    // via request, engine and output registers
    localparam int MAX_IDLE     = 18;

    // one predicted output item
    typedef struct {
        logic [7:0] frame_byte;
        logic       last_byte;
    } frame_item_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;    // [15:0] object_index, [47:16] data_value
    logic        s_tuser;    // [0] wide_data
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // [7:0] frame_byte
    logic        m_tlast;    // last_byte

    // bench copy of the node address register
    logic [7:0]  node_addr_model;

    // frame bytes still owed by the block, oldest first
    frame_item_t frame_bytes_q[$];

    int          error_count;
    int          cycle_count;
    int          frames_sent;
    int          wide_frames;
    int          bytes_checked;
    int          node_writes;

    // idle control shared by the test tasks, send_request and the receiver process
    bit          tx_no_gap;
    bit          rx_no_stall;
    int          rx_hold_req;

    crc8_write_frame_builder u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run limit of %0d cycles reached, %0d bytes still owed",
                     $time, CYCLE_LIMIT, frame_bytes_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    // reflected crc-8, bit-serial form: data enters lsb first
    function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = r[0] ^ b[i];
            r  = r >> 1;
            if (fb)
            begin
                r = r ^ crc8wfb_pkg::CRC_POLY;
            end
        end
        return r;
    endfunction

    // append one predicted byte; covered bytes also go into the running crc
    function automatic void push_frame_byte(input logic [7:0] b, input logic last,
                                            input bit covered, inout logic [7:0] crc);
        frame_item_t it;
        it.frame_byte = b;
        it.last_byte  = last;
        frame_bytes_q.push_back(it);
        if (covered)
        begin
            crc = crc_fold(crc, b);
        end
    endfunction

    // whole frame for one accepted write request
    function automatic void predict_write_frame(input crc8wfb_pkg::write_req_t req);
        logic [7:0] crc;
        int         nbytes;
        crc    = crc8wfb_pkg::CRC_INIT;
        nbytes = req.wide_data ? 4 : 2;
        push_frame_byte(crc8wfb_pkg::FRAME_START, 1'b0, 1'b0, crc);
        push_frame_byte(req.wide_data ? crc8wfb_pkg::FRAME_LEN_WIDE
                                      : crc8wfb_pkg::FRAME_LEN_SHORT,
                        1'b0, 1'b1, crc);
        push_frame_byte(node_addr_model, 1'b0, 1'b1, crc);
        push_frame_byte(crc8wfb_pkg::FRAME_MODE_WRITE, 1'b0, 1'b1, crc);
        push_frame_byte(req.object_index[7:0], 1'b0, 1'b1, crc);
        push_frame_byte(req.object_index[15:8], 1'b0, 1'b1, crc);
        push_frame_byte(crc8wfb_pkg::FRAME_SUBINDEX, 1'b0, 1'b1, crc);
        // data little-endian; short frames drop the upper half
        for (int k = 0; k < nbytes; k++)
        begin
            push_frame_byte(req.data_value[8*k +: 8], 1'b0, 1'b1, crc);
        end
        push_frame_byte(crc, 1'b0, 1'b0, crc);
        push_frame_byte(crc8wfb_pkg::FRAME_END, 1'b1, 1'b0, crc);
    endfunction

    // offer one request item, return at the edge that takes it
    task automatic send_request(input logic [15:0] idx, input logic [31:0] value,
                                input logic wide);
        crc8wfb_pkg::write_req_t req;
        int                      gap;
        req.object_index = idx;
        req.data_value   = value;
        req.wide_data    = wide;
        gap = tx_no_gap ? 0 : $urandom_range(0, MAX_IDLE);
        // valid only drops when there is a real gap, so back-to-back stays high
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {req.data_value, req.object_index};
        s_tuser  <= req.wide_data;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        predict_write_frame(req);
        frames_sent++;
        if (wide)
        begin
            wide_frames++;
        end
    endtask

    // stop offering and wait until every owed byte has come out
    task automatic wait_frames_done();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (frame_bytes_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (frame_bytes_q.size() != 0)
        begin
            $display("%0t: %0d frame bytes never arrived", $time, frame_bytes_q.size());
            error_count += frame_bytes_q.size();
            frame_bytes_q.delete();
        end
        // a byte may still sit in the output stage
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // node address write, only while the block is idle
    task automatic write_node_address(input logic [7:0] addr);
        wait_frames_done();
        cfg_we    <= 1'b1;
        cfg_wdata <= addr;
        @(posedge clk);
        cfg_we    <= 1'b0;
        node_addr_model = addr;
        node_writes++;
    endtask

    // receiver: random stall before each item, plus an optional long hold-off
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        forever
        begin
            if (rx_hold_req > 0)
            begin
                m_tready <= 1'b0;
                repeat (rx_hold_req) @(posedge clk);
                rx_hold_req = 0;
            end
            stall = rx_no_stall ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!(rst_n && m_tvalid));
        end
    end

    // compare each taken output item with the oldest owed byte
    always @(posedge clk)
    begin
        frame_item_t exp_item;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (frame_bytes_q.size() == 0)
            begin
                $display("%0t: unexpected frame byte: expected none, got data %02h last %0b",
                         $time, m_tdata, m_tlast);
                error_count++;
            end
            else
            begin
                exp_item = frame_bytes_q.pop_front();
                bytes_checked++;
                if (m_tdata !== exp_item.frame_byte)
                begin
                    $display("%0t: frame_byte mismatch: expected %02h, got %02h",
                             $time, exp_item.frame_byte, m_tdata);
                    error_count++;
                end
                if (m_tlast !== exp_item.last_byte)
                begin
                    $display("%0t: last_byte mismatch: expected %0b, got %0b",
                             $time, exp_item.last_byte, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // field extremes at the reset node address, short data with upper bits set
    task automatic test_field_extremes();
        send_request(16'h0000, 32'h0000_0000, 1'b0);
        send_request(16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        send_request(16'hFFFF, 32'hFFFF_0000, 1'b0);   // upper half must be ignored
        send_request(16'h0000, 32'hFFFF_FFFF, 1'b0);
        send_request(16'h0000, 32'h0000_0000, 1'b1);
        send_request(16'h1234, 32'h89AB_CDEF, 1'b1);
        send_request(16'h00FF, 32'hA5A5_5A5A, 1'b0);
        send_request(16'hFF00, 32'h8000_0001, 1'b1);
    endtask

    // node address values go out unchanged: both ends and a mixed pattern
    task automatic test_node_address();
        write_node_address(8'h00);
        send_request(16'h6040, 32'h0000_000F, 1'b0);
        send_request(16'h607A, 32'h7FFF_FFFF, 1'b1);
        write_node_address(8'hFF);
        send_request(16'h6040, 32'hDEAD_BEEF, 1'b0);
        send_request(16'h607A, 32'h8000_0000, 1'b1);
        write_node_address(8'h5A);
        send_request(16'hA55A, 32'h0123_4567, 1'b1);
    endtask

    // long receiver hold-off while requests keep coming back to back
    task automatic test_output_backpressure();
        wait_frames_done();
        rx_hold_req = 150;
        tx_no_gap   = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            send_request(16'($urandom), $urandom, 1'($urandom));
        end
        tx_no_gap = 1'b0;
    endtask

    // sender pauses until all frames are out, then resumes
    task automatic test_sender_pause();
        for (int i = 0; i < 3; i++)
        begin
            send_request(16'($urandom), $urandom, 1'($urandom));
        end
        wait_frames_done();
        for (int i = 0; i < 3; i++)
        begin
            send_request(16'($urandom), $urandom, 1'($urandom));
        end
    endtask

    // random requests in four phases, each with its own node address and idling mix
    task automatic test_random_requests();
        for (int phase = 0; phase < 4; phase++)
        begin
            write_node_address(8'($urandom_range(0, 255)));
            tx_no_gap   = (phase == 1) || (phase == 2);
            rx_no_stall = (phase == 1) || (phase == 3);
            for (int i = 0; i < 20; i++)
            begin
                send_request(16'($urandom_range(0, 65535)), $urandom, 1'($urandom_range(0, 1)));
            end
        end
        tx_no_gap   = 1'b0;
        rx_no_stall = 1'b0;
    endtask

    initial
    begin
        error_count     = 0;
        cycle_count     = 0;
        frames_sent     = 0;
        wide_frames     = 0;
        bytes_checked   = 0;
        node_writes     = 0;
        tx_no_gap       = 1'b0;
        rx_no_stall     = 1'b0;
        rx_hold_req     = 0;
        node_addr_model = crc8wfb_pkg::NODE_ADDR_RESET;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= 8'h00;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_node_address();
        test_output_backpressure();
        test_sender_pause();
        test_random_requests();
        wait_frames_done();

        $display("covered %0d write frames (%0d wide, %0d short), %0d bytes checked,",
                 frames_sent, wide_frames, frames_sent - wide_frames, bytes_checked);
        $display("%0d node address writes, long output hold-off and sender pause; %0d errors",
                 node_writes, error_count);
        if (error_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/crc8wfb_pkg.sv
rtl/crc8wfb_frame_mux.sv
rtl/crc8_write_frame_builder.sv
sim/crc8_write_frame_builder_tb.sv
